@@ hdl/mbet_pkg.sv @@
// shared types, constants and reset values of the escape-time pixel block
`default_nettype none

package mbet_pkg;

  // default parameter values
  localparam int ITER_LIMIT_MAX_DEF = 4096;
  localparam int COORD_BITS_DEF     = 12;
  localparam int FRACTION_BITS_DEF  = 44;

  // fixed field widths
  localparam int CFG_W    = 48;
  localparam int ORIGIN_W = 48;
  localparam int STEP_W   = 47;
  localparam int ITER_W   = 13;
  localparam int COLOR_W  = 8;
  localparam int KW       = 13;

  // register reset values
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_RE_RST  = -48'sd36943590693274;
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_IM_RST  = -48'sd21110623253299;
  localparam logic        [STEP_W-1:0]   PIXEL_STEP_RST = 47'd41231686042;
  localparam logic        [ITER_W-1:0]   MAX_ITER_RST   = 13'd256;

  // register indexes
  localparam logic [1:0] CFG_ORIGIN_RE  = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_IM  = 2'd1;
  localparam logic [1:0] CFG_PIXEL_STEP = 2'd2;
  localparam logic [1:0] CFG_MAX_ITER   = 2'd3;

  // colour scale factors: 255*9, 255*15 and 255*17 (blue divides by two more)
  localparam logic [KW-1:0] K_RED   = 13'd2295;
  localparam logic [KW-1:0] K_GREEN = 13'd3825;
  localparam logic [KW-1:0] K_BLUE  = 13'd4335;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_CI,
    ST_UPD,
    ST_PREP,
    ST_MUL,
    ST_FIN,
    ST_COL
  } state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DEN,
    CS_LOAD,
    CS_MUL,
    CS_DIV,
    CS_DONE
  } col_state_t;

endpackage

`default_nettype wire

@@ hdl/mbet_colour.sv @@
// colour unit: polynomial numerators and lim^4 on one multiplier, then 8-bit restoring division
`default_nettype none

module mbet_colour #(
  parameter int ITER_LIMIT_MAX = mbet_pkg::ITER_LIMIT_MAX_DEF,
  localparam int CNT_W = $clog2(ITER_LIMIT_MAX + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] n,
  input  wire logic [CNT_W-1:0] lim,
  output logic                  done,
  output mbet_pkg::rgb_t        rgb
);

  localparam int NW = 4 * CNT_W + mbet_pkg::KW;
  localparam int YW = (CNT_W > mbet_pkg::KW) ? CNT_W : mbet_pkg::KW;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  mbet_pkg::col_state_t cst_r, cst_nxt;

  logic [NW-1:0]      den_r;
  logic [NW-1:0]      num_r;
  logic [NW-1:0]      div_r;
  logic [CNT_W-1:0]   a_r;
  logic [CNT_W-1:0]   b_r;
  logic [CNT_W-1:0]   lim_r;
  logic [1:0]         ch_r;
  logic [2:0]         cnt_r;
  logic [7:0]         q_r;
  mbet_pkg::rgb_t     rgb_r;

  logic [NW-1:0]      mul_x;
  logic [YW-1:0]      mul_y;
  logic [YW-1:0]      k_sel;
  logic               use_b;
  logic [NW+YW-1:0]   prod_full;
  logic [NW-1:0]      mul_p;
  logic               ge;
  logic [7:0]         q_val;

  // operand pattern per channel: red a,a,b,k  green a,b,b,k  blue b,b,b,k
  always_comb begin
    case (ch_r)
      CH_RED:   use_b = (cnt_r == 3'd2);
      CH_GREEN: use_b = (cnt_r != 3'd0);
      default:  use_b = 1'b1;
    endcase
    case (ch_r)
      CH_RED:   k_sel = YW'(mbet_pkg::K_RED);
      CH_GREEN: k_sel = YW'(mbet_pkg::K_GREEN);
      default:  k_sel = YW'(mbet_pkg::K_BLUE);
    endcase
    if (cst_r == mbet_pkg::CS_DEN) begin
      mul_x = den_r;
      mul_y = YW'(lim_r);
    end else begin
      mul_x = num_r;
      if (cnt_r == 3'd3) begin
        mul_y = k_sel;
      end else if (use_b) begin
        mul_y = YW'(b_r);
      end else begin
        mul_y = YW'(a_r);
      end
    end
  end

  assign prod_full = (NW + YW)'(mul_x) * (NW + YW)'(mul_y);
  assign mul_p     = prod_full[NW-1:0];
  assign ge        = (num_r >= div_r);
  assign q_val     = {q_r[6:0], ge};

  // next state
  always_comb begin
    cst_nxt = cst_r;
    unique case (cst_r)
      mbet_pkg::CS_IDLE: if (start) cst_nxt = mbet_pkg::CS_DEN;
      mbet_pkg::CS_DEN:  if (cnt_r == 3'd2) cst_nxt = mbet_pkg::CS_LOAD;
      mbet_pkg::CS_LOAD: cst_nxt = mbet_pkg::CS_MUL;
      mbet_pkg::CS_MUL:  if (cnt_r == 3'd3) cst_nxt = mbet_pkg::CS_DIV;
      mbet_pkg::CS_DIV: begin
        if (cnt_r == 3'd7) begin
          cst_nxt = (ch_r == CH_BLUE) ? mbet_pkg::CS_DONE : mbet_pkg::CS_LOAD;
        end
      end
      mbet_pkg::CS_DONE: cst_nxt = mbet_pkg::CS_IDLE;
      default:           cst_nxt = mbet_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (cst_r == mbet_pkg::CS_DONE);
    rgb  = rgb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= mbet_pkg::CS_IDLE;
    end else begin
      cst_r <= cst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cst_r)
      mbet_pkg::CS_IDLE: begin
        den_r <= NW'(lim);
        lim_r <= lim;
        a_r   <= n;
        b_r   <= lim - n;
        ch_r  <= CH_RED;
        cnt_r <= 3'd0;
      end
      mbet_pkg::CS_DEN: begin
        den_r <= mul_p;
        cnt_r <= (cnt_r == 3'd2) ? 3'd0 : cnt_r + 3'd1;
      end
      mbet_pkg::CS_LOAD: begin
        num_r <= NW'(a_r);
        // blue carries the extra halving of its scale factor
        div_r <= (ch_r == CH_BLUE) ? (den_r << 8) : (den_r << 7);
        cnt_r <= 3'd0;
      end
      mbet_pkg::CS_MUL: begin
        num_r <= mul_p;
        cnt_r <= (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
      end
      mbet_pkg::CS_DIV: begin
        if (ge) num_r <= num_r - div_r;
        div_r <= div_r >> 1;
        q_r   <= q_val;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          case (ch_r)
            CH_RED:   rgb_r.red   <= q_val;
            CH_GREEN: rgb_r.green <= q_val;
            default:  rgb_r.blue  <= q_val;
          endcase
          ch_r <= ch_r + 2'd1;
        end
      end
      mbet_pkg::CS_DONE: begin
        cnt_r <= 3'd0;
      end
      default: begin
        cnt_r <= 3'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/mandelbrot_escape_time_pixel.sv @@
// top level: escape-time iteration of one pixel on a shared half-width multiplier
//
// One pixel goes in when start is high and busy is low; busy then stays high until the
// result has been written, and the result shows for exactly one cycle with out_valid.
// The receiver cannot stall: a result must be taken in the cycle it is shown. The point c
// is formed in the states CX, CY and CI. Each iteration runs an update state, an escape
// check state and a multiply state in which a single multiplier of about half the operand
// width builds zr*zr, zi*zi and zr*zi from four partial products each. A pixel escapes
// when zr*zr + zi*zi reaches four, or without the squares when a component already has
// magnitude two or more; it then passes through the colour unit (lim^4, three numerators
// on one multiplier, three 8-step divisions). A pixel at the limit is inside the set.
// Register writes on the cfg port are taken at any time but are meant for idle periods only.
`default_nettype none

module mandelbrot_escape_time_pixel #(
  parameter int ITER_LIMIT_MAX = mbet_pkg::ITER_LIMIT_MAX_DEF,
  parameter int COORD_BITS     = mbet_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS  = mbet_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [COORD_BITS-1:0]         in_pixel_x,
  input  wire logic [COORD_BITS-1:0]         in_pixel_y,
  output logic                               out_valid,
  output logic [mbet_pkg::COLOR_W-1:0]       out_red,
  output logic [mbet_pkg::COLOR_W-1:0]       out_green,
  output logic [mbet_pkg::COLOR_W-1:0]       out_blue,
  output logic                               out_inside_set,
  output logic [mbet_pkg::ITER_W-1:0]        out_iteration_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [mbet_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(ITER_LIMIT_MAX + 1);
  localparam int ZW    = FRACTION_BITS + 5;
  localparam int H     = (FRACTION_BITS + 2) / 2;
  localparam int MAGW  = 2 * H;
  localparam int AW    = 4 * H + 1;
  localparam int PW    = COORD_BITS + mbet_pkg::STEP_W;
  localparam int SW0   = COORD_BITS + mbet_pkg::STEP_W + 2;
  localparam int CSW   = (SW0 > FRACTION_BITS + 4) ? SW0 : FRACTION_BITS + 4;

  localparam logic signed [ZW-1:0]  TWO     = ZW'(1) << (FRACTION_BITS + 1);
  localparam logic signed [ZW-1:0]  NEG_TWO = -TWO;
  localparam logic signed [ZW-1:0]  FOUR    = ZW'(1) << (FRACTION_BITS + 2);
  localparam logic signed [CSW-1:0] C_HI    = CSW'(1) << (FRACTION_BITS + 2);
  localparam logic signed [CSW-1:0] C_LO    = -C_HI;

  localparam logic [1:0] PR_RR = 2'd0;
  localparam logic [1:0] PR_II = 2'd1;
  localparam logic [1:0] PR_RI = 2'd2;
  localparam logic [3:0] MSTEPS = 4'd12;

  mbet_pkg::state_t state_r, state_nxt;

  // configuration
  logic signed [mbet_pkg::ORIGIN_W-1:0] origin_re_r;
  logic signed [mbet_pkg::ORIGIN_W-1:0] origin_im_r;
  logic        [mbet_pkg::STEP_W-1:0]   pixel_step_r;
  logic        [mbet_pkg::ITER_W-1:0]   max_iter_r;

  // pixel datapath
  logic [COORD_BITS-1:0]  px_r;
  logic [COORD_BITS-1:0]  py_r;
  logic [CNT_W-1:0]       lim_r;
  logic [CNT_W-1:0]       n_r;
  logic [PW-1:0]          cprod_r;
  logic signed [ZW-1:0]   cre_r;
  logic signed [ZW-1:0]   cim_r;
  logic signed [ZW-1:0]   zr_r;
  logic signed [ZW-1:0]   zi_r;
  logic signed [ZW-1:0]   p_rr_r;
  logic signed [ZW-1:0]   p_ii_r;
  logic signed [ZW-1:0]   p_ri_r;
  logic [MAGW-1:0]        mag_re_r;
  logic [MAGW-1:0]        mag_im_r;
  logic                   sre_r;
  logic                   sim_r;
  logic [3:0]             mstep_r;
  logic [MAGW-1:0]        pp_r;
  logic signed [AW-1:0]   acc_r;

  // result
  logic                          out_valid_r;
  mbet_pkg::rgb_t                res_rgb_r;
  logic                          res_inside_r;
  logic [mbet_pkg::ITER_W-1:0]   res_count_r;

  // combinational
  logic                   accept;
  logic                   at_lim;
  logic                   col_start;
  logic                   col_done;
  mbet_pkg::rgb_t         col_rgb;
  logic                   res_load;
  logic [CNT_W-1:0]       lim_calc;
  logic [COORD_BITS-1:0]  coord_sel;
  logic [PW-1:0]          cprod_nxt;
  logic signed [mbet_pkg::ORIGIN_W-1:0] origin_sel;
  logic signed [CSW-1:0]  csum;
  logic signed [CSW-1:0]  cval;
  logic signed [ZW-1:0]   sq_sum;
  logic                   esc_sum;
  logic signed [ZW-1:0]   zr_nxt;
  logic signed [ZW-1:0]   zi_nxt;
  logic                   esc_mag;
  logic [1:0]             mul_pi;
  logic [MAGW-1:0]        op_a;
  logic [MAGW-1:0]        op_b;
  logic [H-1:0]           a_half;
  logic [H-1:0]           b_half;
  logic [MAGW-1:0]        pp_nxt;
  logic [3:0]             tag;
  logic [1:0]             sh_sel;
  logic signed [AW-1:0]   term;
  logic                   term_neg;
  logic signed [AW-1:0]   acc_sum;

  // limit: zero acts as one, clipped to the supported maximum
  always_comb begin
    if (max_iter_r == '0) begin
      lim_calc = CNT_W'(1);
    end else if (32'(max_iter_r) > 32'(ITER_LIMIT_MAX)) begin
      lim_calc = CNT_W'(ITER_LIMIT_MAX);
    end else begin
      lim_calc = CNT_W'(max_iter_r);
    end
  end

  // c = origin + coordinate * step, clamped to [-4, 4]
  assign coord_sel  = (state_r == mbet_pkg::ST_CX) ? px_r : py_r;
  assign cprod_nxt  = PW'(coord_sel) * PW'(pixel_step_r);
  assign origin_sel = (state_r == mbet_pkg::ST_CY) ? origin_re_r : origin_im_r;
  assign csum       = CSW'(origin_sel) + CSW'($signed({1'b0, cprod_r}));

  always_comb begin
    if (csum > C_HI) begin
      cval = C_HI;
    end else if (csum < C_LO) begin
      cval = C_LO;
    end else begin
      cval = csum;
    end
  end

  // iteration update and escape tests
  assign sq_sum  = p_rr_r + p_ii_r;
  assign esc_sum = (sq_sum >= FOUR);
  assign zr_nxt  = p_rr_r - p_ii_r + cre_r;
  assign zi_nxt  = p_ri_r + cim_r;
  assign esc_mag = (zr_r >= TWO) || (zr_r <= NEG_TWO) || (zi_r >= TWO) || (zi_r <= NEG_TWO);
  assign at_lim  = (n_r == lim_r);

  // shared multiplier: product index in mstep[3:2], operand halves in mstep[1:0]
  assign mul_pi = mstep_r[3:2];
  assign op_a   = (mul_pi == PR_II) ? mag_im_r : mag_re_r;
  assign op_b   = (mul_pi == PR_RR) ? mag_re_r : mag_im_r;
  assign a_half = mstep_r[1] ? op_a[MAGW-1:H] : op_a[H-1:0];
  assign b_half = mstep_r[0] ? op_b[MAGW-1:H] : op_b[H-1:0];
  assign pp_nxt = MAGW'(a_half) * MAGW'(b_half);

  // accumulate the registered partial product of the previous step
  assign tag      = mstep_r - 4'd1;
  assign sh_sel   = {1'b0, tag[1]} + {1'b0, tag[0]};
  assign term_neg = (tag[3:2] == PR_RI) && (sre_r ^ sim_r);

  always_comb begin
    case (sh_sel)
      2'd2:    term = AW'(pp_r) << (2 * H);
      2'd1:    term = AW'(pp_r) << H;
      default: term = AW'(pp_r);
    endcase
    acc_sum = term_neg ? (acc_r - term) : (acc_r + term);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbet_pkg::ST_IDLE: if (accept) state_nxt = mbet_pkg::ST_CX;
      mbet_pkg::ST_CX:   state_nxt = mbet_pkg::ST_CY;
      mbet_pkg::ST_CY:   state_nxt = mbet_pkg::ST_CI;
      mbet_pkg::ST_CI:   state_nxt = mbet_pkg::ST_UPD;
      mbet_pkg::ST_UPD:  state_nxt = esc_sum ? mbet_pkg::ST_FIN : mbet_pkg::ST_PREP;
      mbet_pkg::ST_PREP: state_nxt = (esc_mag || at_lim) ? mbet_pkg::ST_FIN : mbet_pkg::ST_MUL;
      mbet_pkg::ST_MUL:  if (mstep_r == MSTEPS) state_nxt = mbet_pkg::ST_UPD;
      mbet_pkg::ST_FIN:  state_nxt = at_lim ? mbet_pkg::ST_IDLE : mbet_pkg::ST_COL;
      mbet_pkg::ST_COL:  if (col_done) state_nxt = mbet_pkg::ST_IDLE;
      default:           state_nxt = mbet_pkg::ST_IDLE;
    endcase
  end

  // outputs and control strobes
  always_comb begin
    busy      = (state_r != mbet_pkg::ST_IDLE);
    accept    = start && (state_r == mbet_pkg::ST_IDLE);
    col_start = (state_r == mbet_pkg::ST_FIN) && !at_lim;
    res_load  = ((state_r == mbet_pkg::ST_FIN) && at_lim) ||
                ((state_r == mbet_pkg::ST_COL) && col_done);
    cfg_ready = 1'b1;
    out_valid           = out_valid_r;
    out_red             = res_rgb_r.red;
    out_green           = res_rgb_r.green;
    out_blue            = res_rgb_r.blue;
    out_inside_set      = res_inside_r;
    out_iteration_count = res_count_r;
  end

  mbet_colour #(
    .ITER_LIMIT_MAX (ITER_LIMIT_MAX)
  ) u_colour (
    .clk   (clk),
    .rst_n (rst_n),
    .start (col_start),
    .n     (n_r),
    .lim   (lim_r),
    .done  (col_done),
    .rgb   (col_rgb)
  );

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mbet_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      origin_re_r  <= mbet_pkg::ORIGIN_RE_RST;
      origin_im_r  <= mbet_pkg::ORIGIN_IM_RST;
      pixel_step_r <= mbet_pkg::PIXEL_STEP_RST;
      max_iter_r   <= mbet_pkg::MAX_ITER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_load;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mbet_pkg::CFG_ORIGIN_RE:  origin_re_r  <= cfg_data;
          mbet_pkg::CFG_ORIGIN_IM:  origin_im_r  <= cfg_data;
          mbet_pkg::CFG_PIXEL_STEP: pixel_step_r <= cfg_data[mbet_pkg::STEP_W-1:0];
          mbet_pkg::CFG_MAX_ITER:   max_iter_r   <= cfg_data[mbet_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      mbet_pkg::ST_IDLE: begin
        if (accept) begin
          px_r  <= in_pixel_x;
          py_r  <= in_pixel_y;
          lim_r <= lim_calc;
        end
      end
      mbet_pkg::ST_CX: begin
        cprod_r <= cprod_nxt;
      end
      mbet_pkg::ST_CY: begin
        cre_r   <= ZW'(cval);
        cprod_r <= cprod_nxt;
      end
      mbet_pkg::ST_CI: begin
        cim_r  <= ZW'(cval);
        p_rr_r <= '0;
        p_ii_r <= '0;
        p_ri_r <= '0;
        n_r    <= '0;
      end
      mbet_pkg::ST_UPD: begin
        if (!esc_sum) begin
          zr_r <= zr_nxt;
          zi_r <= zi_nxt;
          n_r  <= n_r + CNT_W'(1);
        end
      end
      mbet_pkg::ST_PREP: begin
        // magnitudes are only used when both components are below two
        mag_re_r <= MAGW'(zr_r[ZW-1] ? -zr_r : zr_r);
        mag_im_r <= MAGW'(zi_r[ZW-1] ? -zi_r : zi_r);
        sre_r    <= zr_r[ZW-1];
        sim_r    <= zi_r[ZW-1];
        acc_r    <= '0;
        mstep_r  <= '0;
      end
      mbet_pkg::ST_MUL: begin
        if (mstep_r != MSTEPS) pp_r <= pp_nxt;
        if (mstep_r != 4'd0) begin
          if (tag[1:0] == 2'b11) begin
            acc_r <= '0;
            case (tag[3:2])
              PR_RR:   p_rr_r <= ZW'(acc_sum >>> FRACTION_BITS);
              PR_II:   p_ii_r <= ZW'(acc_sum >>> FRACTION_BITS);
              default: p_ri_r <= ZW'(acc_sum >>> (FRACTION_BITS - 1));
            endcase
          end else begin
            acc_r <= acc_sum;
          end
        end
        mstep_r <= mstep_r + 4'd1;
      end
      mbet_pkg::ST_FIN: begin
        if (at_lim) begin
          res_rgb_r    <= '0;
          res_inside_r <= 1'b1;
          res_count_r  <= mbet_pkg::ITER_W'(n_r);
        end
      end
      mbet_pkg::ST_COL: begin
        if (col_done) begin
          res_rgb_r    <= col_rgb;
          res_inside_r <= 1'b0;
          res_count_r  <= mbet_pkg::ITER_W'(n_r);
        end
      end
      default: begin
        mstep_r <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ test/tb.sv @@
// testbench for the escape-time pixel block: directed table, then random views checked by a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = mbet_pkg::FRACTION_BITS_DEF;
  localparam int LIMIT_MAX   = mbet_pkg::ITER_LIMIT_MAX_DEF;
  localparam int CW          = mbet_pkg::COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 50;

  localparam logic signed [63:0] TWO_Q  = 64'sd2 <<< FRAC;
  localparam logic signed [63:0] FOUR_Q = 64'sd4 <<< FRAC;

  // Q4.44 values used by the directed rows
  localparam logic [mbet_pkg::CFG_W-1:0] Q_MAX       = {1'b0, {47{1'b1}}};
  localparam logic [mbet_pkg::CFG_W-1:0] Q_MIN       = {1'b1, 47'd0};
  localparam logic [mbet_pkg::CFG_W-1:0] Q_MINUS_TWO = -48'sd35184372088832;
  localparam logic [mbet_pkg::CFG_W-1:0] Q_ONE_HALF  = 48'sd26388279066624;
  localparam logic [mbet_pkg::CFG_W-1:0] Q_IM_LOW    = -48'sd21990232555520;
  localparam logic [mbet_pkg::CFG_W-1:0] Q_CUSP      = 48'sd4398113619968;
  localparam logic [mbet_pkg::CFG_W-1:0] STEP_VIEW   = 48'd10737418240;

  // random view origins lie in a one-by-one window from these corners
  localparam logic signed [63:0] VIEW_RE_BASE = -64'sd43980465111040;
  localparam logic signed [63:0] VIEW_IM_BASE = -64'sd26388279066624;

  typedef struct packed {
    mbet_pkg::rgb_t                rgb;
    logic                          in_set;
    logic [mbet_pkg::ITER_W-1:0]   count;
  } pixel_result_t;

  typedef struct packed {
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    pixel_result_t  res;
  } awaited_t;

  typedef enum logic { ROW_WRITE, ROW_PIXEL } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [1:0]                 idx;
    logic [mbet_pkg::CFG_W-1:0] data;
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic                       typed;
    pixel_result_t              want;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [CW-1:0]                 in_pixel_x = '0;
  logic [CW-1:0]                 in_pixel_y = '0;
  logic                          out_valid;
  logic [mbet_pkg::COLOR_W-1:0]  out_red;
  logic [mbet_pkg::COLOR_W-1:0]  out_green;
  logic [mbet_pkg::COLOR_W-1:0]  out_blue;
  logic                          out_inside_set;
  logic [mbet_pkg::ITER_W-1:0]   out_iteration_count;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index = mbet_pkg::CFG_ORIGIN_RE;
  logic [mbet_pkg::CFG_W-1:0]    cfg_data = '0;

  // shadow copy of the register file
  logic signed [mbet_pkg::ORIGIN_W-1:0] view_re = mbet_pkg::ORIGIN_RE_RST;
  logic signed [mbet_pkg::ORIGIN_W-1:0] view_im = mbet_pkg::ORIGIN_IM_RST;
  logic [mbet_pkg::STEP_W-1:0]          view_step = mbet_pkg::PIXEL_STEP_RST;
  logic [mbet_pkg::ITER_W-1:0]          iter_limit = mbet_pkg::MAX_ITER_RST;

  awaited_t  awaited_pixels[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int inside_seen = 0;
  int deepest = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  mandelbrot_escape_time_pixel DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_inside_set      (out_inside_set),
    .out_iteration_count (out_iteration_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact product, floored back by sh fraction bits
  function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a, b,
                                                   input int sh);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = wa * wb;
    return 64'(prod >>> sh);
  endfunction

  function automatic logic signed [63:0] clamp_four(input logic signed [63:0] v);
    if (v > FOUR_Q) return FOUR_Q;
    if (v < -FOUR_Q) return -FOUR_Q;
    return v;
  endfunction

  // floor(k * poly / (lim^4 * div))
  function automatic logic [mbet_pkg::COLOR_W-1:0] colour_level(
      input logic [mbet_pkg::KW-1:0] k,
      input logic [63:0] poly, lim,
      input logic [1:0] div);
    logic [127:0] num, den, q;
    num = 128'(k) * 128'(poly);
    den = 128'(lim) * 128'(lim) * 128'(lim) * 128'(lim) * 128'(div);
    q = num / den;
    return q[mbet_pkg::COLOR_W-1:0];
  endfunction

  function automatic pixel_result_t shade_pixel(input logic [CW-1:0] px, py);
    logic signed [63:0] cre, cim, zr, zi, zr2, zi2, nzi;
    logic [63:0] lim, n, a, b;
    logic escaped;
    pixel_result_t r;
    lim = 64'(iter_limit);
    if (lim == 0) lim = 1;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;
    cre = clamp_four(view_re + $signed(64'(px) * 64'(view_step)));
    cim = clamp_four(view_im + $signed(64'(py) * 64'(view_step)));
    zr = '0;
    zi = '0;
    zr2 = '0;
    zi2 = '0;
    n = '0;
    escaped = 1'b0;
    while (!escaped && n < lim) begin
      // new zi uses the old zr
      nzi = mul_floor(zr, zi, FRAC - 1) + cim;
      zr = zr2 - zi2 + cre;
      zi = nzi;
      n++;
      escaped = (zr >= TWO_Q) || (zr <= -TWO_Q) || (zi >= TWO_Q) || (zi <= -TWO_Q);
      if (!escaped) begin
        zr2 = mul_floor(zr, zr, FRAC);
        zi2 = mul_floor(zi, zi, FRAC);
        escaped = (zr2 + zi2 >= FOUR_Q);
      end
    end
    r = '0;
    if (n == lim) begin
      r.in_set = 1'b1;
    end else begin
      a = n;
      b = lim - n;
      r.rgb.red   = colour_level(mbet_pkg::K_RED, b * a * a * a, lim, 2'd1);
      r.rgb.green = colour_level(mbet_pkg::K_GREEN, b * b * a * a, lim, 2'd1);
      r.rgb.blue  = colour_level(mbet_pkg::K_BLUE, b * b * b * a, lim, 2'd2);
    end
    r.count = n[mbet_pkg::ITER_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx,
                                        input logic [mbet_pkg::CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t pix_row(input logic [CW-1:0] x, y);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.x = x;
    r.y = y;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [CW-1:0] x, y,
                                          input logic [mbet_pkg::COLOR_W-1:0] red, green, blue,
                                          input logic in_set,
                                          input logic [mbet_pkg::ITER_W-1:0] count);
    stim_row_t r;
    r = pix_row(x, y);
    r.typed = 1'b1;
    r.want.rgb.red = red;
    r.want.rgb.green = green;
    r.want.rgb.blue = blue;
    r.want.in_set = in_set;
    r.want.count = count;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input awaited_t w,
                             input logic [15:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0d, want %0d",
                                w.x, w.y, name, got, want));
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [mbet_pkg::CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      mbet_pkg::CFG_ORIGIN_RE:  view_re = data[mbet_pkg::ORIGIN_W-1:0];
      mbet_pkg::CFG_ORIGIN_IM:  view_im = data[mbet_pkg::ORIGIN_W-1:0];
      mbet_pkg::CFG_PIXEL_STEP: view_step = data[mbet_pkg::STEP_W-1:0];
      mbet_pkg::CFG_MAX_ITER:   iter_limit = data[mbet_pkg::ITER_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // drop start and wait until every pixel has come back and the block is idle
  task automatic settle();
    if (start) start <= 1'b0;
    while (awaited_pixels.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [CW-1:0] x, y, input pixel_result_t want,
                            input int gap);
    awaited_t w;
    in_pixel_x <= x;
    in_pixel_y <= y;
    start <= 1'b1;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);
    w.x = x;
    w.y = y;
    w.res = want;
    awaited_pixels.push_back(w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    awaited_t w;
    if (rst_n && out_valid) begin
      if (awaited_pixels.size() == 0) begin
        report_mismatch("result arrived with no pixel outstanding");
      end else begin
        w = awaited_pixels.pop_front();
        check_field("red", w, out_red, w.res.rgb.red);
        check_field("green", w, out_green, w.res.rgb.green);
        check_field("blue", w, out_blue, w.res.rgb.blue);
        check_field("inside_set", w, out_inside_set, w.res.in_set);
        check_field("iteration_count", w, out_iteration_count, w.res.count);
        results_seen++;
        if (out_inside_set) inside_seen++;
        if (out_iteration_count > deepest) deepest = out_iteration_count;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, awaited_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    pixel_result_t want;
    logic [CW-1:0] x, y;
    logic no_idle;
    int hold_at;
    int lim;

    // reset view
    directed_rows.push_back(known_row(0, 0, 0, 0, 8, 1'b0, 1));
    directed_rows.push_back(pix_row(4095, 4095));
    directed_rows.push_back(pix_row(876, 512));
    directed_rows.push_back(pix_row(600, 300));
    // a limit of one always lands in the set; zero acts as one
    directed_rows.push_back(reg_row(mbet_pkg::CFG_MAX_ITER, 1));
    directed_rows.push_back(known_row(876, 512, 0, 0, 0, 1'b1, 1));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_MAX_ITER, 0));
    directed_rows.push_back(known_row(1234, 2345, 0, 0, 0, 1'b1, 1));
    // c = 1.5 escapes on the last of two iterations, still in the set
    directed_rows.push_back(reg_row(mbet_pkg::CFG_MAX_ITER, 2));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, Q_ONE_HALF));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_IM, 0));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_PIXEL_STEP, 0));
    directed_rows.push_back(known_row(4095, 0, 0, 0, 0, 1'b1, 2));
    // magnitude of two escapes without the squares
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, Q_MINUS_TWO));
    directed_rows.push_back(known_row(0, 0, 143, 239, 135, 1'b0, 1));
    // far-out c gets clamped
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, Q_MAX));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_IM, Q_MIN));
    directed_rows.push_back(known_row(0, 4095, 143, 239, 135, 1'b0, 1));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, Q_MIN));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_IM, Q_MAX));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_PIXEL_STEP, Q_MAX));
    directed_rows.push_back(known_row(4095, 4095, 143, 239, 135, 1'b0, 1));
    directed_rows.push_back(known_row(0, 0, 143, 239, 135, 1'b0, 1));
    // limit above the maximum acts as the maximum
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, 0));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_IM, 0));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_PIXEL_STEP, 0));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_MAX_ITER, 8191));
    directed_rows.push_back(known_row(0, 0, 0, 0, 0, 1'b1, 4096));
    // just past the cusp: slow escape under the largest limit
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, Q_CUSP));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_MAX_ITER, 4096));
    directed_rows.push_back(pix_row(4095, 0));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_RE, Q_MINUS_TWO));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_ORIGIN_IM, Q_IM_LOW));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_PIXEL_STEP, STEP_VIEW));
    directed_rows.push_back(reg_row(mbet_pkg::CFG_MAX_ITER, 255));
    directed_rows.push_back(pix_row(2048, 2048));
    directed_rows.push_back(pix_row(3276, 2048));
    directed_rows.push_back(pix_row(1000, 3000));
    directed_rows.push_back(pix_row(3500, 100));
    directed_rows.push_back(pix_row(4095, 1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_register(row.idx, row.data);
      end else begin
        want = row.typed ? row.want : shade_pixel(row.x, row.y);
        send_pixel(row.x, row.y, want, $urandom_range(0, 13));
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if ($urandom_range(0, 7) == 0) begin
        write_register(mbet_pkg::CFG_ORIGIN_RE, 48'({$urandom(), $urandom()}));
        write_register(mbet_pkg::CFG_ORIGIN_IM, 48'({$urandom(), $urandom()}));
        write_register(mbet_pkg::CFG_PIXEL_STEP, 48'({$urandom(), $urandom()}) >> 1);
      end else begin
        write_register(mbet_pkg::CFG_ORIGIN_RE,
                       48'(VIEW_RE_BASE + (64'($urandom()) << 12)));
        write_register(mbet_pkg::CFG_ORIGIN_IM,
                       48'(VIEW_IM_BASE + (64'($urandom()) << 12)));
        write_register(mbet_pkg::CFG_PIXEL_STEP, 48'(64'($urandom_range(256, 4096)) << 22));
      end
      // keep limits low so the run stays short; one deeper phase, one at the bottom
      case (phase)
        4:       lim = $urandom_range(100, 300);
        7:       lim = $urandom_range(0, 3);
        default: lim = $urandom_range(2, 40);
      endcase
      write_register(mbet_pkg::CFG_MAX_ITER, 48'(lim));
      no_idle = ($urandom_range(0, 3) == 0);
      hold_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        x = CW'($urandom());
        y = CW'($urandom());
        if (i == hold_at) settle();
        send_pixel(x, y, shade_pixel(x, y), no_idle ? 0 : $urandom_range(0, 13));
      end
    end

    settle();
    repeat (60) @(posedge clk);
    $display("checked %0d pixels after %0d register writes", results_seen, reg_writes);
    $display("%0d pixels inside the set, deepest count %0d", inside_seen, deepest);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mbet_pkg.sv
hdl/mbet_colour.sv
hdl/mandelbrot_escape_time_pixel.sv
test/tb.sv
